// ===== src/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
// Used by spq_ctrl, spq_datapath and sorted_priority_queue; depends on nothing.
`timescale 1ns / 1ps

package spq_pkg;

  // Number of queue slots (valid range 2..31)
  localparam int DEPTH = 16;

  // Word field widths
  localparam int VALUE_W = 16;
  localparam int PRIO_W  = 8;
  localparam int FUNC_W  = 2;
  localparam int STAT_W  = 2;
  localparam int OUT_CNT_W = 5;

  // Internal count must hold DEPTH and also cover the 5-bit output field
  localparam int CNT_BITS = $clog2(DEPTH + 1);
  localparam int CNT_W    = (CNT_BITS > OUT_CNT_W) ? CNT_BITS : OUT_CNT_W;

  // Operation codes
  localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FN_DELETE = 2'd1;
  localparam logic [FUNC_W-1:0] FN_PEEK   = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  // Controller states
  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic                  load;    // latch the incoming word
    logic                  ins;     // shift-insert latched entry
    logic                  del;     // shift out the head
    logic                  emit;    // register a result word
    logic                  head;    // result carries the head value
    logic [STAT_W-1:0]     status;  // result status code
  } spq_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              full;
    logic              empty;
  } spq_stat_t;

endpackage

// ===== src/spq_ctrl.sv =====
// Controller FSM for the sorted priority queue: accepts a command word,
// decodes it against full/empty status and drives the datapath. Uses spq_pkg.
`timescale 1ns / 1ps

module spq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  spq_pkg::spq_stat_t st,
  output spq_pkg::spq_cmd_t  cmd
);

  spq_pkg::state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.status = spq_pkg::ST_OK;
    busy       = 1'b0;
    case (state_r)
      spq_pkg::S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = spq_pkg::S_EXEC;
        end
      end
      spq_pkg::S_EXEC: begin
        busy      = 1'b1;
        cmd.emit  = 1'b1;
        state_nxt = spq_pkg::S_IDLE;
        case (st.func)
          spq_pkg::FN_INSERT: begin
            if (st.full) begin
              cmd.status = spq_pkg::ST_FULL;
            end else begin
              cmd.ins = 1'b1;
            end
          end
          spq_pkg::FN_DELETE, spq_pkg::FN_PEEK: begin
            if (st.empty) begin
              cmd.status = spq_pkg::ST_EMPTY;
            end else begin
              cmd.head = 1'b1;
              cmd.del  = (st.func == spq_pkg::FN_DELETE);
            end
          end
          default: begin
            // unused selector: no change, plain ok result
          end
        endcase
      end
      default: begin
        state_nxt = spq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== src/spq_datapath.sv =====
// Datapath for the sorted priority queue: command latch, a sorted row of
// (value, prio) cells with parallel compare and shift, and the result register.
// Uses spq_pkg.
`timescale 1ns / 1ps

module spq_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [spq_pkg::FUNC_W-1:0]     in_func,
  input  logic [spq_pkg::VALUE_W-1:0]    in_value,
  input  logic [spq_pkg::PRIO_W-1:0]     in_prio,
  input  spq_pkg::spq_cmd_t              cmd,
  output spq_pkg::spq_stat_t             st,
  output logic                           out_valid,
  output logic [spq_pkg::VALUE_W-1:0]    out_head_value,
  output logic [spq_pkg::STAT_W-1:0]     out_status,
  output logic [spq_pkg::OUT_CNT_W-1:0]  out_count
);

  localparam int D  = spq_pkg::DEPTH;
  localparam int CW = spq_pkg::CNT_W;

  // Latched command word
  logic [spq_pkg::FUNC_W-1:0]  func_r;
  logic [spq_pkg::VALUE_W-1:0] val_r;
  logic [spq_pkg::PRIO_W-1:0]  prio_r;

  // Sorted cell row
  logic [spq_pkg::VALUE_W-1:0] vals_r  [D];
  logic [spq_pkg::VALUE_W-1:0] vals_nxt[D];
  logic [spq_pkg::PRIO_W-1:0]  prios_r  [D];
  logic [spq_pkg::PRIO_W-1:0]  prios_nxt[D];
  logic [CW-1:0]               count_r, count_nxt;

  // Result register
  logic                        out_valid_r;
  logic [spq_pkg::VALUE_W-1:0] out_head_r;
  logic [spq_pkg::STAT_W-1:0]  out_status_r;
  logic [spq_pkg::OUT_CNT_W-1:0] out_count_r;

  // Cell holds a valid entry that stays ahead of the new one
  logic [D-1:0] le;

  always_comb begin
    for (int i = 0; i < D; i++) begin
      le[i] = (CW'(i) < count_r) && (prios_r[i] <= prio_r);
    end
  end

  // Cell next values: insert opens a gap after the last non-greater entry,
  // delete moves every cell after the head one toward the head
  always_comb begin
    for (int i = 0; i < D; i++) begin
      vals_nxt[i]  = vals_r[i];
      prios_nxt[i] = prios_r[i];
    end
    if (cmd.ins) begin
      if (!le[0]) begin
        vals_nxt[0]  = val_r;
        prios_nxt[0] = prio_r;
      end
      for (int i = 1; i < D; i++) begin
        if (!le[i]) begin
          if (le[i-1]) begin
            vals_nxt[i]  = val_r;
            prios_nxt[i] = prio_r;
          end else begin
            vals_nxt[i]  = vals_r[i-1];
            prios_nxt[i] = prios_r[i-1];
          end
        end
      end
    end else if (cmd.del) begin
      for (int i = 0; i < D - 1; i++) begin
        vals_nxt[i]  = vals_r[i+1];
        prios_nxt[i] = prios_r[i+1];
      end
    end
  end

  // Entry count after this operation
  always_comb begin
    count_nxt = count_r;
    if (cmd.ins) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.del) begin
      count_nxt = count_r - CW'(1);
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= cmd.emit;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      val_r  <= in_value;
      prio_r <= in_prio;
    end
    for (int i = 0; i < D; i++) begin
      vals_r[i]  <= vals_nxt[i];
      prios_r[i] <= prios_nxt[i];
    end
    if (cmd.emit) begin
      out_head_r   <= cmd.head ? vals_r[0] : '0;
      out_status_r <= cmd.status;
      out_count_r  <= count_nxt[spq_pkg::OUT_CNT_W-1:0];
    end
  end

  // Status to controller
  assign st.func  = func_r;
  assign st.full  = (count_r >= CW'(D));
  assign st.empty = (count_r == '0);

  assign out_valid      = out_valid_r;
  assign out_head_value = out_head_r;
  assign out_status     = out_status_r;
  assign out_count      = out_count_r;

endmodule

// ===== src/sorted_priority_queue.sv =====
// Sorted priority queue top level: joins the controller and the datapath.
// Depends on spq_pkg, spq_ctrl and spq_datapath.
//
// Usage:
//   Command channel: drive in_func / in_value / in_prio and raise start; the
//   word is taken at a rising edge where start is high and busy is low.
//   in_func: insert, delete head, peek head (code 3 does nothing).
//   Result channel: out_valid is high for exactly one cycle with
//   out_head_value, out_status (ok, full, empty) and out_count, the entry
//   count after the operation. The receiver cannot stall; every word is
//   shown once and must be taken in that cycle.
//   Timing: the word is latched at the accepting edge and executed in the
//   execute state, and the result word is registered as that state ends,
//   raising out_valid. A new command is taken only in the idle state, so
//   not while the previous one executes; the cell row compares all entries
//   in parallel so insert and delete each finish within the execute state.
//   busy is high during the execute state; a new command may be accepted
//   while the previous result is on the out_ ports.
//   Reset (rst_n low, synchronous): the queue becomes empty and no result
//   is pending; stored values need no clearing since only held entries are read.
`timescale 1ns / 1ps

module sorted_priority_queue (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [spq_pkg::FUNC_W-1:0]     in_func,
  input  logic [spq_pkg::VALUE_W-1:0]    in_value,
  input  logic [spq_pkg::PRIO_W-1:0]     in_prio,
  output logic                           out_valid,
  output logic [spq_pkg::VALUE_W-1:0]    out_head_value,
  output logic [spq_pkg::STAT_W-1:0]     out_status,
  output logic [spq_pkg::OUT_CNT_W-1:0]  out_count
);

  spq_pkg::spq_cmd_t  cmd;
  spq_pkg::spq_stat_t st;

  // Sequencer
  spq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .st    (st),
    .cmd   (cmd)
  );

  // Cell row and result register
  spq_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_func        (in_func),
    .in_value       (in_value),
    .in_prio        (in_prio),
    .cmd            (cmd),
    .st             (st),
    .out_valid      (out_valid),
    .out_head_value (out_head_value),
    .out_status     (out_status),
    .out_count      (out_count)
  );

endmodule
